>>> rtl/lkv_pkg.sv
package lkv_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 16;
  localparam int CFG_BITS   = 5;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int AGE_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [AGE_W-1:0]      age_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // Outcome of the parallel search over all entries.
  typedef struct packed {
    logic hit;
    idx_t hit_idx;
    val_t hit_value;
    age_t hit_age;
    idx_t oldest_idx;
    idx_t free_idx;
  } lookup_t;

endpackage

>>> rtl/lkv_lookup.sv
module lkv_lookup
  import lkv_pkg::*;
(
  input  key_t               key,
  input  logic [ENTRIES-1:0] entry_valid,
  input  key_t               entry_key [ENTRIES],
  input  val_t               entry_value [ENTRIES],
  input  age_t               entry_age [ENTRIES],
  input  cnt_t               occupied_count,
  output lookup_t            lk
);

  age_t oldest_age;

  assign oldest_age = AGE_W'(occupied_count - cnt_t'(1));

  // Scanning from the top down leaves the lowest matching slot selected.
  always_comb begin
    lk = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (entry_valid[i] && entry_key[i] == key) begin
        lk.hit     = 1'b1;
        lk.hit_idx = IDX_W'(i);
      end
      if (entry_valid[i] && entry_age[i] == oldest_age) begin
        lk.oldest_idx = IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        lk.free_idx = IDX_W'(i);
      end
    end
    lk.hit_value = entry_value[lk.hit_idx];
    lk.hit_age   = entry_age[lk.hit_idx];
  end

endmodule

>>> rtl/lkv_store.sv
module lkv_store
  import lkv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic               item_valid,
  input  logic               item_op,
  input  key_t               item_key,
  input  val_t               item_value,
  input  lookup_t            lk,
  output logic [ENTRIES-1:0] entry_valid,
  output key_t               entry_key [ENTRIES],
  output val_t               entry_value [ENTRIES],
  output age_t               entry_age [ENTRIES],
  output cnt_t               occupied_count
);

  cnt_t capacity;
  logic full;
  logic touch;
  logic wr_key;
  logic wr_val;
  logic insert;
  idx_t slot;
  age_t old_age;

  assign full = (occupied_count >= capacity) && (occupied_count != '0);

  always_comb begin
    touch   = 1'b0;
    wr_key  = 1'b0;
    wr_val  = 1'b0;
    insert  = 1'b0;
    slot    = '0;
    old_age = '0;
    if (item_valid) begin
      if (lk.hit) begin
        touch   = 1'b1;
        slot    = lk.hit_idx;
        old_age = lk.hit_age;
        wr_val  = (item_op == OP_PUT);
      end else if (item_op == OP_PUT) begin
        touch  = 1'b1;
        wr_key = 1'b1;
        wr_val = 1'b1;
        if (full) begin
          slot    = lk.oldest_idx;
          old_age = AGE_W'(occupied_count - cnt_t'(1));
        end else begin
          // Not full means occupancy is below the entry count, so it fits an age.
          slot    = lk.free_idx;
          old_age = AGE_W'(occupied_count);
          insert  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid    <= '0;
      occupied_count <= '0;
      capacity       <= CNT_W'(ENTRIES);
      for (int i = 0; i < ENTRIES; i++) begin
        entry_age[i] <= '0;
      end
    end else begin
      if (cfg_we && occupied_count == '0) begin
        if (cfg_data == '0) begin
          capacity <= cnt_t'(1);
        end else if (int'(cfg_data) > ENTRIES) begin
          capacity <= CNT_W'(ENTRIES);
        end else begin
          capacity <= CNT_W'(cfg_data);
        end
      end
      if (insert) begin
        entry_valid[slot] <= 1'b1;
        occupied_count    <= occupied_count + cnt_t'(1);
      end
      if (touch) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == slot) begin
            entry_age[i] <= '0;
          end else if (entry_valid[i] && entry_age[i] < old_age) begin
            entry_age[i] <= entry_age[i] + age_t'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_key) begin
      entry_key[slot] <= item_key;
    end
    if (wr_val) begin
      entry_value[slot] <= item_value;
    end
  end

endmodule

>>> rtl/lru_key_value_cache_top.sv
// Channel  | Signals                         | Transfer condition
// ---------+---------------------------------+---------------------------------
// command  | start, busy, opcode, key_in,    | rising edge with start high and
//          | value_in                        | busy low
// result   | done, found, value_out          | rising edge ending a done cycle
// config   | cfg_we, cfg_data                | rising edge with cfg_we high
//
// A new command can be taken in every cycle that busy is low. A get's
// result passes through the command register, then the parallel search and
// state update that loads the result register. Puts produce no result.
// Reset is synchronous and busy is high while rst is asserted; the cache
// comes out of reset empty, with no clearing pass. The receiver cannot
// stall, so nothing ever holds a result back.
module lru_key_value_cache_top
  import lkv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                opcode,
  input  logic [KEY_BITS-1:0] key_in,
  input  logic [VALUE_BITS-1:0] value_in,
  output logic                done,
  output logic                found,
  output logic [VALUE_BITS-1:0] value_out,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_data
);

  // Command register. Its contents are searched against the state that the
  // previous command left, so back-to-back commands see each other's effects.
  logic item_valid;
  logic item_op;
  key_t item_key;
  val_t item_value;

  logic [ENTRIES-1:0] entry_valid;
  key_t               entry_key [ENTRIES];
  val_t               entry_value [ENTRIES];
  age_t               entry_age [ENTRIES];
  cnt_t               occupied_count;
  lookup_t            lk;

  logic done_next;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_op    <= opcode;
      item_key   <= key_in;
      item_value <= value_in;
    end
  end

  lkv_lookup u_lookup (
    .key            (item_key),
    .entry_valid    (entry_valid),
    .entry_key      (entry_key),
    .entry_value    (entry_value),
    .entry_age      (entry_age),
    .occupied_count (occupied_count),
    .lk             (lk)
  );

  lkv_store u_store (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_op        (item_op),
    .item_key       (item_key),
    .item_value     (item_value),
    .lk             (lk),
    .entry_valid    (entry_valid),
    .entry_key      (entry_key),
    .entry_value    (entry_value),
    .entry_age      (entry_age),
    .occupied_count (occupied_count)
  );

  // Only gets answer. A miss reports zero rather than any sentinel value.
  assign done_next = item_valid && (item_op == OP_GET);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (done_next) begin
      found     <= lk.hit;
      value_out <= lk.hit ? lk.hit_value : '0;
    end
  end

endmodule

>>> rtl/lkv_checker.sv
module lkv_checker
  import lkv_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  opcode,
  input logic                  done,
  input logic                  found,
  input logic [VALUE_BITS-1:0] value_out
);

  logic get_xfer;
  logic put_xfer;

  assign get_xfer = start && !busy && opcode == OP_GET;
  assign put_xfer = start && !busy && opcode == OP_PUT;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  a_get_answers: assert property (@(posedge clk) disable iff (rst)
    get_xfer |-> ##2 done)
    else $error("get without a result");

  a_put_silent: assert property (@(posedge clk) disable iff (rst)
    put_xfer |-> ##2 !done)
    else $error("put produced a result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(get_xfer, 2))
    else $error("result without a get");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !found |-> value_out == '0)
    else $error("miss with nonzero value");

endmodule

bind lru_key_value_cache_top lkv_checker u_lkv_checker (.*);

>>> tb/lru_key_value_cache_top_tb.sv
`timescale 1ns / 1ps

module lru_key_value_cache_top_tb;
  import lkv_pkg::*;

  // Cycles with no transfer of any kind before the run is declared hung.
  // The longest legal quiet stretch is a long random sender gap or the short
  // settle wait before a capacity write, both far below this.
  localparam int STALL_LIMIT = 2000;
  // A get answers through the command and result registers; puts settle just as fast.
  localparam int SETTLE_CYCLES = 3;
  localparam int DRAIN_LIMIT = 200;
  localparam int ITEMS_PER_PHASE = 440;

  typedef struct {
    logic op;
    key_t key;
    val_t value;
  } cache_cmd_t;

  typedef struct {
    logic hit;
    val_t value;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic opcode = OP_GET;
  key_t key_in = '0;
  val_t value_in = '0;
  logic cfg_we = 1'b0;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic busy;
  logic done;
  logic found;
  val_t value_out;

  lru_key_value_cache_top uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .key_in(key_in),
    .value_in(value_in),
    .done(done),
    .found(found),
    .value_out(value_out),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Commands waiting to be driven, and lookup answers waiting to come back.
  cache_cmd_t cmd_queue[$];
  lookup_result_t pending_lookups[$];

  int queued_count = 0;
  int accepted_count = 0;
  int error_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;

  // Shadow copy of the cache contents. Ages count up from 0 for the most
  // recently used entry, so valid entries always hold 0..occupancy-1.
  logic slot_valid[ENTRIES];
  key_t slot_key[ENTRIES];
  val_t slot_value[ENTRIES];
  int slot_age[ENTRIES];
  int occupancy = 0;
  int capacity = ENTRIES;

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i] = '0;
      slot_value[i] = '0;
      slot_age[i] = 0;
    end
  end

  task automatic report_mismatch(input string what, input int expected_val, input int actual_val);
    $display("[%0t] mismatch: %s expected %0h got %0h", $time, what, expected_val, actual_val);
    error_count++;
  endtask

  // Make slot s the most recent entry. Entries that were more recent than
  // it get one step older; older entries keep their age.
  task automatic promote(input int s, input int old_age);
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && i != s && slot_age[i] < old_age) slot_age[i]++;
    end
    slot_age[s] = 0;
  endtask

  // A capacity write only lands while the cache holds nothing. Zero is taken
  // as one entry and anything past the array size saturates to it.
  task automatic apply_capacity(input logic [CFG_BITS-1:0] v);
    if (occupancy == 0) begin
      if (v == 0) capacity = 1;
      else if (int'(v) > ENTRIES) capacity = ENTRIES;
      else capacity = int'(v);
    end
  endtask

  // Apply one command to the shadow cache. A get queues the answer it
  // must produce; a put updates, evicts or inserts and answers nothing.
  task automatic predict_access(input cache_cmd_t c);
    int i;
    int hit_slot;
    int oldest;
    lookup_result_t r;
    hit_slot = -1;
    for (i = 0; i < ENTRIES; i++) begin
      if (hit_slot < 0 && slot_valid[i] && slot_key[i] == c.key) hit_slot = i;
    end
    if (c.op == OP_GET) begin
      if (hit_slot >= 0) begin
        r.hit = 1'b1;
        r.value = slot_value[hit_slot];
        promote(hit_slot, slot_age[hit_slot]);
      end else begin
        // A miss answers found low with a zero value, no sentinel.
        r.hit = 1'b0;
        r.value = '0;
      end
      pending_lookups.push_back(r);
    end else if (hit_slot >= 0) begin
      slot_value[hit_slot] = c.value;
      promote(hit_slot, slot_age[hit_slot]);
    end else if (occupancy >= capacity && occupancy > 0) begin
      // Full: the least recently used entry gives up its slot.
      oldest = occupancy - 1;
      for (i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i] && slot_age[i] == oldest) begin
          slot_key[i] = c.key;
          slot_value[i] = c.value;
          promote(i, oldest);
          break;
        end
      end
    end else begin
      for (i = 0; i < ENTRIES; i++) begin
        if (!slot_valid[i]) begin
          slot_valid[i] = 1'b1;
          slot_key[i] = c.key;
          slot_value[i] = c.value;
          promote(i, occupancy);
          occupancy++;
          break;
        end
      end
    end
  endtask

  // Driver. The command slot is free when nothing is presented or when the
  // presented command transfers at this edge; a command that has not
  // transferred yet stays on the ports untouched.
  always @(posedge clk) begin
    cache_cmd_t c;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        c = cmd_queue.pop_front();
        start <= 1'b1;
        opcode <= c.op;
        key_in <= c.key;
        value_in <= c.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. Results are checked before a command that transfers at the
  // same edge is predicted; no get can answer in the cycle it transfers, so
  // this order never pairs a result with its own command.
  always @(posedge clk) begin
    lookup_result_t exp_r;
    cache_cmd_t c;
    if (!rst) begin
      if (done) begin
        if (pending_lookups.size() == 0) begin
          report_mismatch("result with no lookup outstanding, found", 0, found);
        end else begin
          exp_r = pending_lookups.pop_front();
          if (found !== exp_r.hit) report_mismatch("found", exp_r.hit, found);
          if (value_out !== exp_r.value) report_mismatch("value_out", exp_r.value, value_out);
        end
      end
      if (cfg_we) apply_capacity(cfg_data);
      if (start && !busy) begin
        c.op = opcode;
        c.key = key_in;
        c.value = value_in;
        predict_access(c);
        accepted_count <= accepted_count + 1;
      end
    end
  end

  // Watchdog: any command, result or register transfer counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_cmd(input logic op, input key_t key, input val_t value);
    cache_cmd_t c;
    c.op = op;
    c.key = key;
    c.value = value;
    cmd_queue.push_back(c);
    queued_count++;
  endtask

  task automatic wait_until_quiet();
    while (accepted_count != queued_count || pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Capacity writes happen only with the cache quiet: every command has
  // transferred, every answer is back and the last put has settled.
  task automatic write_capacity(input logic [CFG_BITS-1:0] v);
    wait_until_quiet();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  key_t key_pool[32];

  // Stimulus. The cache never empties once a put lands, so the capacity
  // that governs the run is the last one written before the first put. The
  // seed picks it, zero and oversized writes included. Every later write
  // hits a non-empty cache and must be ignored.
  initial begin
    int phase;
    int n;
    int i;
    int span;
    int pick;
    logic [CFG_BITS-1:0] final_cap;
    key_t k;
    val_t v;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (i = 2; i < 32; i++) key_pool[i] = key_t'($urandom());

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 25;

    // Lookups on an empty cache miss, whatever capacity is set.
    write_capacity('0);
    queue_cmd(OP_GET, '0, '1);
    write_capacity('1);
    queue_cmd(OP_GET, '1, '0);
    pick = $urandom_range(0, 3);
    if (pick == 0) final_cap = '0;
    else if (pick == 1) final_cap = CFG_BITS'($urandom_range(ENTRIES + 1, 31));
    else final_cap = CFG_BITS'($urandom_range(1, ENTRIES));
    write_capacity(final_cap);

    // Extreme keys and values, hits, a miss that carries a value, an
    // overwrite, then enough fresh keys to force an eviction.
    queue_cmd(OP_PUT, '0, '1);
    queue_cmd(OP_PUT, '1, '0);
    queue_cmd(OP_GET, '0, '0);
    queue_cmd(OP_GET, '1, '0);
    queue_cmd(OP_GET, key_t'(1), '1);
    queue_cmd(OP_PUT, '0, val_t'(16'h1234));
    queue_cmd(OP_GET, '0, '0);
    for (i = 0; i <= capacity; i++) queue_cmd(OP_PUT, key_t'(16'h8000 + i), val_t'(~i));
    queue_cmd(OP_GET, key_t'(16'h8000), '0);
    queue_cmd(OP_GET, key_t'(16'h8000 + capacity), '0);

    // Keys come mostly from a pool a little larger than the capacity, so
    // hits, overwrites and evictions are all frequent; the rest are drawn
    // from the whole key space.
    span = (capacity + 3 > 31) ? 31 : capacity + 3;
    for (phase = 0; phase < 3; phase++) begin
      write_capacity(CFG_BITS'($urandom_range(0, 31)));
      send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 73 : 0;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, span)];
        else k = key_t'($urandom());
        pick = $urandom_range(0, 15);
        if (pick == 0) v = '0;
        else if (pick == 1) v = '1;
        else v = val_t'($urandom());
        queue_cmd(($urandom_range(0, 99) < 50) ? OP_GET : OP_PUT, k, v);
      end
    end

    while (accepted_count != queued_count) @(posedge clk);
    n = 0;
    while (pending_lookups.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES + 1) @(posedge clk);
    while (pending_lookups.size() != 0) begin
      void'(pending_lookups.pop_front());
      report_mismatch("lookup never answered, outstanding", 0, 1);
    end

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/lkv_pkg.sv
rtl/lkv_lookup.sv
rtl/lkv_store.sv
rtl/lru_key_value_cache_top.sv
rtl/lkv_checker.sv
tb/lru_key_value_cache_top_tb.sv
